@@ rtl/core/ivac_pkg.sv @@
// Shared types, constants and the classful mask function of the interface address classifier.
package ivac_pkg;

    // Classful network masks.
    localparam logic [31:0] CLASS_A_MASK = 32'hFF00_0000;
    localparam logic [31:0] CLASS_B_MASK = 32'hFFFF_0000;
    localparam logic [31:0] CLASS_C_MASK = 32'hFFFF_FF00;

    // Operation codes carried by an item.
    typedef enum logic [1:0] {
        OP_INSTALL = 2'd0,
        OP_QUERY   = 2'd1,
        OP_COMPOSE = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    // One input item as held in the input register.
    typedef struct packed {
        t_op         operation;
        logic [2:0]  entry_index;
        logic [31:0] address;
        logic [31:0] subnet_mask;
        logic [31:0] network_number;
        logic [31:0] host_number;
        logic        broadcast_capable;
    } t_item;

    // One interface table entry.
    typedef struct packed {
        logic [31:0] net;
        logic [31:0] class_mask;
        logic [31:0] subnet_mask;
        logic [31:0] subnet;
        logic [31:0] broadcast_address;
        logic        broadcast_enable;
    } t_entry;

    // Table write request produced by an install.
    typedef struct packed {
        logic       en;
        logic [2:0] index;
        t_entry     entry;
    } t_write;

    // One result item.
    typedef struct packed {
        logic [31:0] net_of_address;
        logic [31:0] host_of_address;
        logic        is_local;
        logic        is_broadcast;
        logic [31:0] composed_address;
        logic        found;
        logic [2:0]  found_index;
    } t_result;

    // Class A when bit 31 is clear, class B for leading 10, class C otherwise.
    function automatic logic [31:0] class_net_mask(input logic [31:0] a);
        logic [31:0] m;
        priority if (!a[31]) begin
            m = CLASS_A_MASK;
        end else if (!a[30]) begin
            m = CLASS_B_MASK;
        end else begin
            m = CLASS_C_MASK;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/ivac_table.sv @@
// Interface table storage: per-entry valid bits and the entry contents.
module ivac_table #(
    parameter int ENTRIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ivac_pkg::t_write  i_write,
    output logic [ENTRIES-1:0] o_valid,
    output ivac_pkg::t_entry  o_entries [ENTRIES]
);

    logic [ENTRIES-1:0] r_valid;
    ivac_pkg::t_entry   r_entries [ENTRIES];

    // Valid bits are cleared by reset and set by an install to their slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < ENTRIES; k++) begin
                if (i_write.en && ({29'd0, i_write.index} == 32'(k))) begin
                    r_valid[k] <= 1'b1;
                end
            end
        end
    end

    // Entry contents are only read once their valid bit is set.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (i_write.en && ({29'd0, i_write.index} == 32'(k))) begin
                r_entries[k] <= i_write.entry;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_entries = r_entries;

endmodule

@@ rtl/core/ivac_lookup.sv @@
// Parallel mask-and-compare over all table entries with lowest-slot priority.
module ivac_lookup #(
    parameter int ENTRIES = 8
) (
    input  logic               i_item_valid,
    input  ivac_pkg::t_item    i_item,
    input  logic [ENTRIES-1:0] i_valid,
    input  ivac_pkg::t_entry   i_entries [ENTRIES],
    output ivac_pkg::t_result  o_result,
    output ivac_pkg::t_write   o_write
);

    logic               in_range;
    logic               install_we;
    ivac_pkg::t_entry   new_entry;
    logic [ENTRIES-1:0] view_valid;
    ivac_pkg::t_entry   view [ENTRIES];
    logic [31:0]        c_net;
    logic [31:0]        c_host;
    logic [31:0]        c_mask;
    logic [31:0]        composed;
    logic [31:0]        q_cm;
    logic [31:0]        q_cnet;
    logic [31:0]        q_net;
    logic [31:0]        q_host;
    logic               q_local;
    logic               q_bcast;
    logic               f_found;
    logic [2:0]         f_index;

    // New entry fields derived from the install item.
    always_comb begin
        in_range   = ({29'd0, i_item.entry_index} < 32'(ENTRIES));
        install_we = i_item_valid && (i_item.operation == ivac_pkg::OP_INSTALL) && in_range;
        new_entry.class_mask        = ivac_pkg::class_net_mask(i_item.address);
        new_entry.net               = i_item.address & new_entry.class_mask;
        new_entry.subnet_mask       = i_item.subnet_mask | new_entry.class_mask;
        new_entry.subnet            = i_item.address & new_entry.subnet_mask;
        new_entry.broadcast_enable  = i_item.broadcast_capable;
        new_entry.broadcast_address = '0;
    end

    // Table as seen after the pending install, so the broadcast address uses it.
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (install_we && ({29'd0, i_item.entry_index} == 32'(k))) begin
                view_valid[k] = 1'b1;
                view[k]       = new_entry;
            end else begin
                view_valid[k] = i_valid[k];
                view[k]       = i_entries[k];
            end
        end
    end

    // Compose unit, shared by compose and by the broadcast address of an install.
    always_comb begin
        if (i_item.operation == ivac_pkg::OP_INSTALL) begin
            c_net  = new_entry.subnet;
            c_host = '1;
        end else begin
            c_net  = i_item.network_number;
            c_host = i_item.host_number;
        end
        c_mask = ~ivac_pkg::class_net_mask(c_net);
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (view_valid[k] && ((view[k].class_mask & c_net) == view[k].net)) begin
                c_mask = ~view[k].subnet_mask;
            end
        end
        composed = c_net | (c_host & c_mask);
    end

    // Query: first entry on the same classful net supplies the subnet mask.
    always_comb begin
        q_cm    = ivac_pkg::class_net_mask(i_item.address);
        q_cnet  = i_item.address & q_cm;
        q_net   = q_cnet;
        q_host  = i_item.address & ~q_cm;
        q_local = 1'b0;
        q_bcast = 1'b0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (view_valid[k] && (view[k].net == q_cnet)) begin
                q_net   = i_item.address & view[k].subnet_mask;
                q_host  = (i_item.address & ~q_cm) & ~view[k].subnet_mask;
                q_local = 1'b1;
            end
        end
        for (int k = 0; k < ENTRIES; k++) begin
            if (view_valid[k] && view[k].broadcast_enable &&
                (view[k].broadcast_address == i_item.address)) begin
                q_bcast = 1'b1;
            end
        end
    end

    // Find: lowest slot whose subnet equals the given net.
    always_comb begin
        f_found = 1'b0;
        f_index = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (view_valid[k] && (view[k].subnet == i_item.network_number)) begin
                f_found = 1'b1;
                f_index = 3'(k);
            end
        end
    end

    // Result assembly; fields not belonging to the operation stay zero.
    always_comb begin
        o_result = '0;
        unique case (i_item.operation)
            ivac_pkg::OP_INSTALL: begin
                if (in_range && i_item.broadcast_capable) begin
                    o_result.composed_address = composed;
                end
            end
            ivac_pkg::OP_QUERY: begin
                o_result.net_of_address  = q_net;
                o_result.host_of_address = q_host;
                o_result.is_local        = q_local;
                o_result.is_broadcast    = q_bcast;
            end
            ivac_pkg::OP_COMPOSE: begin
                o_result.composed_address = composed;
            end
            ivac_pkg::OP_FIND: begin
                o_result.found       = f_found;
                o_result.found_index = f_index;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // Table write for an install in range.
    always_comb begin
        o_write.en                       = install_we;
        o_write.index                    = i_item.entry_index;
        o_write.entry                    = new_entry;
        o_write.entry.broadcast_address  = composed;
    end

endmodule

@@ rtl/core/ipv4_interface_address_classifier_unit.sv @@
// Top level of the interface address classifier: input register, table, lookup, result register.
//
// The unit takes one item in every clock cycle while reset is not applied and returns its
// result through two registers: the item is captured in an input register, all table entries
// are masked and compared in parallel in the following cycle, and the result register drives
// the output ports with o_valid high for one cycle. The receiver cannot hold results off. An install
// updates the table at the same edge that registers its result, so the very next item already
// sees the new entry. busy is high only while reset is applied; the table needs no clearing
// pass, since reset clears the entry valid bits at once.
module ipv4_interface_address_classifier_unit #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_entry_index,
    input  logic [31:0] i_address,
    input  logic [31:0] i_subnet_mask,
    input  logic [31:0] i_network_number,
    input  logic [31:0] i_host_number,
    input  logic        i_broadcast_capable,
    output logic        o_valid,
    output logic [31:0] o_net_of_address,
    output logic [31:0] o_host_of_address,
    output logic        o_is_local,
    output logic        o_is_broadcast,
    output logic [31:0] o_composed_address,
    output logic        o_found,
    output logic [2:0]  o_found_index
);

    logic                     accept;
    ivac_pkg::t_item          r_item;
    logic                     r_item_valid;
    ivac_pkg::t_result        r_result;
    logic                     r_out_valid;
    ivac_pkg::t_result        n_result;
    ivac_pkg::t_write         tbl_write;
    logic [TABLE_ENTRIES-1:0] tbl_valid;
    ivac_pkg::t_entry         tbl_entries [TABLE_ENTRIES];

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.operation         <= ivac_pkg::t_op'(i_operation);
            r_item.entry_index       <= i_entry_index;
            r_item.address           <= i_address;
            r_item.subnet_mask       <= i_subnet_mask;
            r_item.network_number    <= i_network_number;
            r_item.host_number       <= i_host_number;
            r_item.broadcast_capable <= i_broadcast_capable;
        end
    end

    // Interface table.
    ivac_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_write   (tbl_write),
        .o_valid   (tbl_valid),
        .o_entries (tbl_entries)
    );

    // Lookup and install logic.
    ivac_lookup #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_lookup (
        .i_item_valid (r_item_valid),
        .i_item       (r_item),
        .i_valid      (tbl_valid),
        .i_entries    (tbl_entries),
        .o_result     (n_result),
        .o_write      (tbl_write)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid            = r_out_valid;
    assign o_net_of_address   = r_result.net_of_address;
    assign o_host_of_address  = r_result.host_of_address;
    assign o_is_local         = r_result.is_local;
    assign o_is_broadcast     = r_result.is_broadcast;
    assign o_composed_address = r_result.composed_address;
    assign o_found            = r_result.found;
    assign o_found_index      = r_result.found_index;

`ifndef SYNTH
    // Every accepted item yields a result once it has passed the input and result registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_valid)
        else $error("accepted item produced no result");

    // No result without an item in the input register the cycle before.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_item_valid))
        else $error("result strobe without a pending item");

    // A find hit always names a slot that exists.
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (32'(o_found_index) < 32'(TABLE_ENTRIES)))
        else $error("found index beyond the table");

    // An install in range marks its slot valid at the next edge.
    a_install_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_write.en |=> (tbl_valid != '0))
        else $error("install left the table empty");
`endif

endmodule
